[design/mipd_pkg.sv]
// shared types and constants of the instruction predecoder
`default_nettype none
package mipd_pkg;

	localparam int ADDR_W   = 21;
	localparam int WORD_W   = 16;
	localparam int AVAIL_W  = 3;
	localparam int CLASS_W  = 5;
	localparam int SIZE_W   = 3;
	localparam int CYC_W    = 2;
	localparam int IN_DW    = 56;
	localparam int OUT_DW   = 56;
	localparam int OUT_USED = CLASS_W + SIZE_W + CYC_W + 1 + ADDR_W + 1 + ADDR_W;

	localparam logic [AVAIL_W-1:0] AVAIL_FULL = 3'd4;
	localparam logic [AVAIL_W-1:0] AVAIL_MIN  = 3'd2;
	localparam logic [SIZE_W-1:0]  SIZE_WORD  = 3'd2;
	localparam logic [SIZE_W-1:0]  SIZE_LONG  = 3'd4;

	typedef enum logic [CLASS_W-1:0] {
		OP_ILLEGAL  = 5'd0,
		OP_CALL     = 5'd1,
		OP_JUMP     = 5'd2,
		OP_CONDJUMP = 5'd3,
		OP_NOP      = 5'd4,
		OP_MOVE     = 5'd5,
		OP_UNKNOWN  = 5'd6,
		OP_ADD      = 5'd7,
		OP_LOAD     = 5'd8,
		OP_MUL      = 5'd9,
		OP_RET      = 5'd10,
		OP_AND      = 5'd11,
		OP_XOR      = 5'd12,
		OP_OR       = 5'd13,
		OP_SUB      = 5'd14,
		OP_STORE    = 5'd15,
		OP_ROL      = 5'd16,
		OP_ROR      = 5'd17,
		OP_COMPL    = 5'd18,
		OP_CMP      = 5'd19,
		OP_PUSH     = 5'd20,
		OP_POP      = 5'd21
	} op_class_t;

	typedef struct packed {
		op_class_t          op_class;
		logic [SIZE_W-1:0]  op_size;
		logic [CYC_W-1:0]   cycle_count;
		logic               jump_valid;
		logic               fail_valid;
		logic               relative;
		logic [ADDR_W-1:0]  offset;
		logic [ADDR_W-1:0]  absolute;
	} dec_info_t;

endpackage
`default_nettype wire

[design/mcu_instruction_predecoder_top.sv]
// instruction predecoder: three-stage pipeline from instruction words to class and targets
//
// Input transfers on s_axis carry one instruction: program byte address, the first
// and second instruction words and the number of fetched bytes. Each produces one
// output transfer on m_axis with the operation class, size in bytes, cycle count,
// and for branches the jump target and the fall-through target.
// Stage 1 registers the decoded class and the branch offset, stage 2 adds the
// offset to the address, stage 3 is the output register.
// The input is registered in stage 1, then in stage 2, then in stage 3, whose valid
// bit drives m_axis_tvalid; one instruction is
// taken every cycle while m_axis_tready is high.
// When the receiver stalls, items pile up in the three stages; s_axis_tready
// falls only once all stages hold data, and nothing is dropped or repeated.
// Reset clears all stage valid bits, so m_axis_tvalid is low and
// s_axis_tready is high right after reset.
// The block keeps no state between instructions.
`default_nettype none
module mcu_instruction_predecoder_top
	import mipd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// pc_address[20:0], first_word[36:21], second_word[52:37], bytes_available[55:53]
	input  wire logic [IN_DW-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// op_class[4:0], op_size[7:5], cycle_count[9:8], jump_valid[10],
	// jump_target[31:11], fail_valid[32], fail_target[53:33], zero[55:54]
	output logic [OUT_DW-1:0]      m_axis_tdata
);

	logic [ADDR_W-1:0]  pc_in;
	logic [WORD_W-1:0]  w1;
	logic [WORD_W-1:0]  w2;
	logic [AVAIL_W-1:0] avail_raw;
	logic [AVAIL_W-1:0] avail;
	logic               long_ok;
	logic               done;
	dec_info_t          dec;

	logic               ready_s1, ready_s2, ready_s3;
	logic               valid_s1, valid_s2, valid_s3;
	dec_info_t          info_s1;
	logic [ADDR_W-1:0]  pc_s1;

	op_class_t          class_s2;
	logic [SIZE_W-1:0]  size_s2;
	logic [CYC_W-1:0]   cyc_s2;
	logic               jv_s2, fv_s2;
	logic [ADDR_W-1:0]  jt_s2, ft_s2;
	logic [ADDR_W-1:0]  pc_next;
	logic [ADDR_W-1:0]  jt_next;

	logic [OUT_USED-1:0] out_s3;

	assign pc_in     = s_axis_tdata[ADDR_W-1:0];
	assign w1        = s_axis_tdata[ADDR_W +: WORD_W];
	assign w2        = s_axis_tdata[ADDR_W+WORD_W +: WORD_W];
	assign avail_raw = s_axis_tdata[ADDR_W+2*WORD_W +: AVAIL_W];
	assign avail     = (avail_raw > AVAIL_FULL) ? AVAIL_FULL : avail_raw;
	assign long_ok   = (avail == AVAIL_FULL) && (w2[15:12] == 4'hF);

	// ordered opcode-field decode
	always_comb begin
		dec.op_class    = OP_ILLEGAL;
		dec.op_size     = SIZE_WORD;
		dec.cycle_count = 2'd0;
		dec.jump_valid  = 1'b0;
		dec.fail_valid  = 1'b0;
		dec.relative    = 1'b0;
		dec.offset      = '0;
		dec.absolute    = '0;
		done            = 1'b1;
		if (avail < AVAIL_MIN) begin
			dec.op_size = avail;
		end else if (w1[15:9] == 7'h76) begin
			if (long_ok) begin
				dec.op_class = OP_CALL;
				dec.op_size  = SIZE_LONG;
			end
		end else if (w1[15:11] == 5'h1B) begin
			dec.op_class = OP_CALL;
		end else if (w1[15:11] == 5'h1A) begin
			dec.op_class    = OP_JUMP;
			dec.cycle_count = 2'd2;
			dec.jump_valid  = 1'b1;
			dec.relative    = 1'b1;
			dec.offset      = {{(ADDR_W-12){w1[10]}}, w1[10:0], 1'b0};
		end else if (w1[15:12] == 4'hF) begin
			dec.op_class    = OP_NOP;
			dec.cycle_count = 2'd1;
		end else if (w1[15:12] == 4'hC) begin
			if (long_ok) begin
				dec.op_class = OP_MOVE;
				dec.op_size  = SIZE_LONG;
			end
		end else if (w1[15:12] == 4'hB || w1[15:12] == 4'hA) begin
			dec.op_class = OP_CONDJUMP;
		end else if (w1[15:12] == 4'h9 || w1[15:12] == 4'h8 || w1[15:12] == 4'h7) begin
			dec.op_class = OP_UNKNOWN;
		end else if (w1[15:11] == 5'h1C) begin
			// conditional relative branch
			dec.op_class    = OP_CONDJUMP;
			dec.cycle_count = 2'd2;
			dec.jump_valid  = 1'b1;
			dec.fail_valid  = 1'b1;
			dec.relative    = 1'b1;
			dec.offset      = {{(ADDR_W-9){w1[7]}}, w1[7:0], 1'b0};
		end else if (w1[15:8] == 8'hEF) begin
			if (long_ok) begin
				dec.op_class    = OP_JUMP;
				dec.op_size     = SIZE_LONG;
				dec.cycle_count = 2'd2;
				dec.jump_valid  = 1'b1;
				dec.absolute    = {w2[11:0], w1[7:0], 1'b0};
			end
		end else if (w1[15:11] == 5'h01) begin
			unique case (w1[10:8])
				3'h7: begin dec.op_class = OP_ADD;  dec.cycle_count = 2'd1; end
				3'h6: begin dec.op_class = OP_LOAD; dec.cycle_count = 2'd1; end
				3'h5: begin dec.op_class = OP_MUL;  dec.cycle_count = 2'd1; end
				3'h4: begin dec.op_class = OP_RET;  dec.cycle_count = 2'd2; end
				3'h3: begin dec.op_class = OP_AND;  dec.cycle_count = 2'd1; end
				3'h2: begin dec.op_class = OP_XOR;  dec.cycle_count = 2'd1; end
				3'h1: begin dec.op_class = OP_OR;   dec.cycle_count = 2'd1; end
				default: begin dec.op_class = OP_SUB; dec.cycle_count = 2'd1; end
			endcase
		end else if (w1[15:6] == 10'h3B8) begin
			if (long_ok) begin
				dec.op_class = OP_LOAD;
				dec.op_size  = SIZE_LONG;
			end
		end else begin
			done = 1'b0;
		end

		if (!done) begin
			done = 1'b1;
			unique case (w1[15:10])
				6'h17, 6'h16, 6'h15, 6'h13, 6'h0B, 6'h01: dec.op_class = OP_SUB;
				6'h14: dec.op_class = OP_MOVE;
				6'h12, 6'h0F, 6'h0A, 6'h08: dec.op_class = OP_ADD;
				6'h09: begin dec.op_class = OP_ADD; dec.cycle_count = 2'd1; end
				6'h11, 6'h0D: dec.op_class = OP_ROL;
				6'h10, 6'h0C: dec.op_class = OP_ROR;
				6'h0E: dec.op_class = OP_UNKNOWN;
				6'h07: dec.op_class = OP_COMPL;
				6'h06: dec.op_class = OP_XOR;
				6'h05: dec.op_class = OP_AND;
				6'h04: dec.op_class = OP_OR;
				default: done = 1'b0;
			endcase
		end

		if (!done) begin
			done = 1'b1;
			unique case (w1[15:9])
				7'h37: dec.op_class = OP_STORE;
				7'h36, 7'h35, 7'h34: dec.op_class = OP_UNKNOWN;
				7'h33: dec.op_class = OP_CONDJUMP;
				7'h32, 7'h31, 7'h30: dec.op_class = OP_CMP;
				7'h01: dec.op_class = OP_MUL;
				default: done = 1'b0;
			endcase
		end

		if (!done && w1[15:4] == 12'h010) begin
			done            = 1'b1;
			dec.op_class    = OP_LOAD;
			dec.cycle_count = 2'd1;
		end

		if (!done) begin
			unique case (w1)
				16'h00FF, 16'h0007, 16'h0004, 16'h0003: dec.op_class = OP_UNKNOWN;
				16'h0013, 16'h0012: begin
					dec.op_class    = OP_RET;
					dec.cycle_count = 2'd2;
				end
				16'h0011, 16'h0010: dec.op_class = OP_RET;
				16'h000F, 16'h000E, 16'h000D, 16'h000C: dec.op_class = OP_LOAD;
				16'h000B, 16'h000A, 16'h0009, 16'h0008: dec.op_class = OP_STORE;
				16'h0006: dec.op_class = OP_POP;
				16'h0005: dec.op_class = OP_PUSH;
				16'h0000: begin
					dec.op_class    = OP_NOP;
					dec.cycle_count = 2'd1;
				end
				default: ;
			endcase
		end
	end

	// stall handling
	assign ready_s3      = !valid_s3 || m_axis_tready;
	assign ready_s2      = !valid_s2 || ready_s3;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_axis_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// stage 1: decoded class and offset
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			info_s1 <= dec;
			pc_s1   <= pc_in;
		end
	end

	// stage 2: target adders
	assign pc_next = pc_s1 + ADDR_W'(2);
	assign jt_next = info_s1.relative ? (pc_next + info_s1.offset) : info_s1.absolute;

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			class_s2 <= info_s1.op_class;
			size_s2  <= info_s1.op_size;
			cyc_s2   <= info_s1.cycle_count;
			jv_s2    <= info_s1.jump_valid;
			fv_s2    <= info_s1.fail_valid;
			jt_s2    <= info_s1.jump_valid ? jt_next : '0;
			ft_s2    <= info_s1.fail_valid ? pc_next : '0;
		end
	end

	// stage 3: output register
	always_ff @(posedge clk) begin
		if (ready_s3) begin
			out_s3 <= {ft_s2, fv_s2, jt_s2, jv_s2, cyc_s2, size_s2, class_s2};
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {{(OUT_DW-OUT_USED){1'b0}}, out_s3};

endmodule
`default_nettype wire
